>>> design/ean13_pkg.sv
`default_nettype none
package ean13_pkg;

  // what follows the first segment of a digit
  localparam logic [1:0] EX_NONE    = 2'd0;
  localparam logic [1:0] EX_CENTER  = 2'd1;
  localparam logic [1:0] EX_CHK_END = 2'd2;
  localparam logic [1:0] EX_END     = 2'd3;

  localparam logic [6:0] EDGE_GUARD   = 7'b0000101;
  localparam logic [6:0] CENTER_GUARD = 7'b0001010;
  localparam logic [2:0] EDGE_COUNT   = 3'd3;
  localparam logic [2:0] CENTER_COUNT = 3'd5;
  localparam logic [2:0] DIGIT_COUNT  = 3'd7;

  localparam logic [3:0] LAST_POS  = 4'd12;
  localparam logic [3:0] CENTER_POS = 4'd6;
  localparam logic [3:0] CHECK_POS = 4'd11;

  // one digit's work as handed from front to back
  typedef struct packed {
    logic [6:0] seg0_modules;
    logic [2:0] seg0_count;
    logic       seg0_guard;
    logic [3:0] seg0_check;
    logic [1:0] extra;
    logic [3:0] check;
    logic       bad;
  } job_t;

  function automatic logic [6:0] code_l(input logic [3:0] d);
    logic [6:0] m;
    case (d)
      4'd0: m = 7'b0001101;
      4'd1: m = 7'b0011001;
      4'd2: m = 7'b0010011;
      4'd3: m = 7'b0111101;
      4'd4: m = 7'b0100011;
      4'd5: m = 7'b0110001;
      4'd6: m = 7'b0101111;
      4'd7: m = 7'b0111011;
      4'd8: m = 7'b0110111;
      4'd9: m = 7'b0001011;
      default: m = 7'b0000000;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] code_g(input logic [3:0] d);
    logic [6:0] m;
    case (d)
      4'd0: m = 7'b0100111;
      4'd1: m = 7'b0110011;
      4'd2: m = 7'b0011011;
      4'd3: m = 7'b0100001;
      4'd4: m = 7'b0011101;
      4'd5: m = 7'b0111001;
      4'd6: m = 7'b0000101;
      4'd7: m = 7'b0010001;
      4'd8: m = 7'b0001001;
      4'd9: m = 7'b0010111;
      default: m = 7'b0000000;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] code_r(input logic [3:0] d);
    logic [6:0] m;
    case (d)
      4'd0: m = 7'b1110010;
      4'd1: m = 7'b1100110;
      4'd2: m = 7'b1101100;
      4'd3: m = 7'b1000010;
      4'd4: m = 7'b1011100;
      4'd5: m = 7'b1001110;
      4'd6: m = 7'b1010000;
      4'd7: m = 7'b1000100;
      4'd8: m = 7'b1001000;
      4'd9: m = 7'b1110100;
      default: m = 7'b0000000;
    endcase
    return m;
  endfunction

  // g/l choice for digits 2..7, msb first, 1 is g
  function automatic logic [5:0] parity_sel(input logic [3:0] d);
    logic [5:0] p;
    case (d)
      4'd1: p = 6'b001011;
      4'd2: p = 6'b001101;
      4'd3: p = 6'b001110;
      4'd4: p = 6'b010011;
      4'd5: p = 6'b011001;
      4'd6: p = 6'b011100;
      4'd7: p = 6'b010101;
      4'd8: p = 6'b010110;
      4'd9: p = 6'b011010;
      default: p = 6'b000000;
    endcase
    return p;
  endfunction

  // values up to 39
  function automatic logic [3:0] mod_ten(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'd30) begin
      r = v - 6'd30;
    end else if (v >= 6'd20) begin
      r = v - 6'd20;
    end else if (v >= 6'd10) begin
      r = v - 6'd10;
    end else begin
      r = v;
    end
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

>>> design/ean13_digit_if.sv
`default_nettype none
interface ean13_digit_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;

  modport source (output valid, output digit, input ready);
  modport sink (input valid, input digit, output ready);
endinterface
`default_nettype wire

>>> design/ean13_segment_if.sv
`default_nettype none
interface ean13_segment_if;
  logic       valid;
  logic       ready;
  logic [6:0] modules;
  logic [2:0] module_count;
  logic       is_guard;
  logic [3:0] check_digit;
  logic       bad_digit;
  logic       last;

  modport source (
    output valid, output modules, output module_count, output is_guard,
    output check_digit, output bad_digit, output last, input ready
  );
  modport sink (
    input valid, input modules, input module_count, input is_guard,
    input check_digit, input bad_digit, input last, output ready
  );
endinterface
`default_nettype wire

>>> design/ean13_front.sv
`default_nettype none
module ean13_front
  import ean13_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  ean13_digit_if.sink digits,
  input  wire logic   queue_full,
  output logic        push,
  output job_t        job
);

  logic       check_source;
  logic [3:0] position;
  logic [5:0] parity;
  logic [3:0] sum;

  logic [3:0] position_next;
  logic [5:0] parity_next;
  logic [3:0] sum_next;

  logic       bad;
  logic [3:0] d;
  logic [3:0] pos;
  logic [5:0] weighted;
  logic [3:0] sum_upd;
  logic [5:0] parity_shifted;
  logic       use_g;
  logic [3:0] computed_check;

  assign digits.ready = !queue_full;
  assign push         = digits.valid && !queue_full;

  assign bad      = digits.digit > 4'd9;
  assign d        = bad ? 4'd0 : digits.digit;
  assign pos      = (position > LAST_POS) ? 4'd0 : position;
  // weight 3 on odd positions
  assign weighted = pos[0] ? ({1'b0, d, 1'b0} + {2'b00, d}) : {2'b00, d};
  assign sum_upd  = mod_ten({2'b00, sum} + weighted);
  assign parity_shifted = parity >> (CENTER_POS - pos);
  assign use_g    = parity_shifted[0];
  assign computed_check = (sum_upd == 4'd0) ? 4'd0 : 4'd10 - sum_upd;

  always_comb begin
    job               = '0;
    job.bad           = bad;
    job.seg0_count    = DIGIT_COUNT;
    job.extra         = EX_NONE;
    position_next     = pos + 4'd1;
    parity_next       = parity;
    sum_next          = sum_upd;
    if (pos == 4'd0) begin
      job.seg0_modules = EDGE_GUARD;
      job.seg0_count   = EDGE_COUNT;
      job.seg0_guard   = 1'b1;
      parity_next      = parity_sel(d);
    end else if (pos <= CENTER_POS) begin
      job.seg0_modules = bad ? 7'd0 : (use_g ? code_g(d) : code_l(d));
      if (pos == CENTER_POS) begin
        job.extra = EX_CENTER;
      end
    end else if (pos == LAST_POS) begin
      // supplied check digit
      job.seg0_modules = bad ? 7'd0 : code_r(d);
      job.seg0_check   = d;
      job.check        = d;
      job.extra        = EX_END;
      position_next    = 4'd0;
      parity_next      = 6'd0;
      sum_next         = 4'd0;
    end else begin
      job.seg0_modules = bad ? 7'd0 : code_r(d);
      if (pos == CHECK_POS && !check_source) begin
        job.extra     = EX_CHK_END;
        job.check     = computed_check;
        position_next = 4'd0;
        parity_next   = 6'd0;
        sum_next      = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_source <= 1'b0;
      position     <= 4'd0;
      parity       <= 6'd0;
      sum          <= 4'd0;
    end else begin
      if (cfg_we) begin
        check_source <= cfg_wdata;
      end
      if (push) begin
        position <= position_next;
        parity   <= parity_next;
        sum      <= sum_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/ean13_queue.sv
`default_nettype none
module ean13_queue
  import ean13_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/ean13_back.sv
`default_nettype none
module ean13_back
  import ean13_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire job_t        head,
  input  wire logic        empty,
  output logic             pop,
  ean13_segment_if.source  segments
);

  logic [1:0] step;
  logic [1:0] last_step;
  logic       load;
  logic       fire;

  logic [6:0] seg_modules;
  logic [2:0] seg_count;
  logic       seg_guard;
  logic [3:0] seg_check;
  logic       seg_last;

  always_comb begin
    unique case (head.extra)
      EX_NONE:    last_step = 2'd0;
      EX_CENTER:  last_step = 2'd1;
      EX_END:     last_step = 2'd1;
      EX_CHK_END: last_step = 2'd2;
      default:    last_step = 2'd0;
    endcase
  end

  always_comb begin
    seg_modules = head.seg0_modules;
    seg_count   = head.seg0_count;
    seg_guard   = head.seg0_guard;
    seg_check   = head.seg0_check;
    seg_last    = 1'b0;
    if (step != 2'd0) begin
      if (head.extra == EX_CENTER) begin
        seg_modules = CENTER_GUARD;
        seg_count   = CENTER_COUNT;
        seg_guard   = 1'b1;
        seg_check   = 4'd0;
      end else if (head.extra == EX_CHK_END && step == 2'd1) begin
        seg_modules = code_r(head.check);
        seg_count   = DIGIT_COUNT;
        seg_guard   = 1'b0;
        seg_check   = head.check;
      end else begin
        // end guard
        seg_modules = EDGE_GUARD;
        seg_count   = EDGE_COUNT;
        seg_guard   = 1'b1;
        seg_check   = head.check;
        seg_last    = 1'b1;
      end
    end
  end

  assign load = !segments.valid || segments.ready;
  assign fire = !empty && load;
  assign pop  = fire && (step == last_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= 2'd0;
      segments.valid <= 1'b0;
    end else begin
      if (fire) begin
        segments.valid <= 1'b1;
        step           <= (step == last_step) ? 2'd0 : step + 2'd1;
      end else if (segments.ready) begin
        segments.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      segments.modules      <= seg_modules;
      segments.module_count <= seg_count;
      segments.is_guard     <= seg_guard;
      segments.check_digit  <= seg_check;
      segments.bad_digit    <= head.bad;
      segments.last         <= seg_last;
    end
  end

endmodule
`default_nettype wire

>>> design/ean13_module_encoder.sv
`default_nettype none
// channel     | dir | handshake     | payload
// ------------+-----+---------------+------------------------------------------------
// digits      | in  | valid / ready | digit[3:0]
// segments    | out | valid / ready | modules[6:0], module_count[2:0], is_guard,
//             |     |               | check_digit[3:0], bad_digit, last
// cfg         | in  | cfg_we        | cfg_wdata = check_source
//
// a digit taken on its handshake gives one to three segments, which leave one
// a cycle through the output register while the sink is ready; the back pops
// a digit's job only once its last segment has been sent
// the first segment of a digit passes through a queue slot, then the output register
// reset is synchronous; digit position, parity, sum and check_source go to zero
// digits keep flowing while segments stall until the job queue fills
module ean13_module_encoder
  import ean13_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // job slots between front and back, 2..8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  ean13_digit_if.sink     digits,
  ean13_segment_if.source segments
);

  // front: tracks position, parity pattern and weighted sum, looks up codes
  job_t push_job;
  logic push;
  job_t head;
  logic pop;
  logic full;
  logic empty;

  ean13_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .digits     (digits),
    .queue_full (full),
    .push       (push),
    .job        (push_job)
  );

  // short job queue so either side may stall on its own
  ean13_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // back: expands each job into its segments, one per cycle while the sink is ready
  ean13_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .segments (segments)
  );

endmodule
`default_nettype wire
